@@ rtl/bqwg_pkg.sv @@
// Shared constants and payload types for the quad warp grid block.
`default_nettype none

package bqwg_pkg;

  // grid size
  localparam int unsigned GRID_COLS = 16;
  localparam int unsigned GRID_ROWS = 16;
  localparam int unsigned COL_MAX   = GRID_COLS - 1;
  localparam int unsigned ROW_MAX   = GRID_ROWS - 1;
  localparam int unsigned CW        = (GRID_COLS > 2) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned RW        = (GRID_ROWS > 2) ? $clog2(GRID_ROWS) : 1;

  // blend weights sum to DIVISOR
  localparam int unsigned DIVISOR   = COL_MAX * ROW_MAX;
  localparam int unsigned HALF      = DIVISOR / 2;
  localparam int unsigned WW        = $clog2(DIVISOR + 1);

  // field widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned EXT_W      = 29;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 29;

  // weighted sum / dividend width
  localparam int unsigned SW        = COORD_W + WW;

  // divide by DIVISOR as a multiply by RECIP_M and a shift by RECIP_K; exact for
  // any dividend below 2^NUM_W; the multiply is split in halves of DIV_HW bits
  localparam int unsigned NUM_W   = SW - 1;
  localparam int unsigned RECIP_K = NUM_W + WW;
  localparam int unsigned DIV_HW  = (SW + 2) / 2;
  localparam logic [2*DIV_HW-1:0] RECIP_M =
    (2 * DIV_HW)'(((64'd1 << RECIP_K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  // texture product widths
  localparam int unsigned PW = COORD_W + EXT_W + 1;
  localparam int unsigned GW = PW - 16;

  // blend channels: destination x/y, source x/y
  localparam int unsigned NCH   = 4;
  localparam int unsigned CH_DX = 0;
  localparam int unsigned CH_DY = 1;
  localparam int unsigned CH_SX = 2;
  localparam int unsigned CH_SY = 3;

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(65536);

  typedef enum logic [1:0] {
    OP_SET_DEST = 2'd0,
    OP_SET_SRC  = 2'd1,
    OP_COMPUTE  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_EXT_S = 2'd0,
    CFG_TEX_EXT_T = 2'd1,
    CFG_FLIP_VERT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [3:0]                grid_col;
    logic [3:0]                grid_row;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] tex_s;
    logic signed [COORD_W-1:0] tex_t;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/bqwg_if.sv @@
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface bqwg_in_if;
  logic               valid;
  logic               ready;
  bqwg_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bqwg_out_if;
  logic                valid;
  logic                ready;
  bqwg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/bqwg_div.sv @@
// Divider by the constant blend divisor as a three-stage reciprocal multiply, four lanes.
`default_nettype none

module bqwg_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [bqwg_pkg::NCH-1:0][bqwg_pkg::SW-1:0]  num_i,
  input  logic [bqwg_pkg::NCH-1:0]                    neg_i,
  output logic                                        valid_o,
  output logic [bqwg_pkg::NCH-1:0][bqwg_pkg::COORD_W-1:0] quot_o,
  output logic [bqwg_pkg::NCH-1:0]                    neg_o
);
  import bqwg_pkg::*;

  // valid and sign travel beside the three multiply stages
  logic [2:0]                   v_q;
  logic [2:0][NCH-1:0]          n_q;

  logic [NCH-1:0][2*DIV_HW-1:0] n_ext;
  logic [NCH-1:0][2*DIV_HW-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [NCH-1:0][2*DIV_HW:0]   mid_q;
  logic [NCH-1:0][4*DIV_HW-1:0] base_q;
  logic [NCH-1:0][4*DIV_HW-1:0] prod;
  logic [NCH-1:0][COORD_W-1:0]  q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      n_ext[ch] = (2 * DIV_HW)'(num_i[ch]);
      prod[ch]  = base_q[ch] + ((4 * DIV_HW)'(mid_q[ch]) << DIV_HW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= {n_q[1:0], neg_i};
      for (int ch = 0; ch < NCH; ch++) begin
        // partial products of split dividend and reciprocal
        ll_q[ch] <= n_ext[ch][DIV_HW-1:0] * RECIP_M[DIV_HW-1:0];
        lh_q[ch] <= n_ext[ch][DIV_HW-1:0] * RECIP_M[2*DIV_HW-1:DIV_HW];
        hl_q[ch] <= n_ext[ch][2*DIV_HW-1:DIV_HW] * RECIP_M[DIV_HW-1:0];
        hh_q[ch] <= n_ext[ch][2*DIV_HW-1:DIV_HW] * RECIP_M[2*DIV_HW-1:DIV_HW];
        // low and high products do not overlap, so they simply concatenate
        mid_q[ch]  <= (2 * DIV_HW + 1)'(lh_q[ch]) + (2 * DIV_HW + 1)'(hl_q[ch]);
        base_q[ch] <= {hh_q[ch], ll_q[ch]};
        q_q[ch]    <= prod[ch][RECIP_K +: COORD_W];
      end
    end
  end

  assign quot_o  = q_q;
  assign valid_o = v_q[2];
  assign neg_o   = n_q[2];

endmodule

`default_nettype wire

@@ rtl/bilinear_quad_warp_grid.sv @@
// Top level of the bilinear quad warp grid point generator.
`default_nettype none

// Bilinear quad warp grid generator. Input words either load one of four
// destination or source quad corners (signed Q16.16 x/y) or ask for the grid
// point at a column/row. For a grid point the block blends the four
// destination corners to a vertex position and the four source corners,
// scaled by the texture extents (optionally flipped vertically), to texture
// coordinates; all rounding is to nearest, ties away from zero, and the
// texture outputs saturate to 32 bits. Rate: one input word per clock, back
// to back, while the skid slot is empty. An accepted word passes these
// register stages in order: operand/weight register, 16 corner-by-weight
// multipliers, four-term sum, rounding offset, a three-stage multiply by the
// reciprocal of (GRID_COLS-1)*(GRID_ROWS-1) (split partial products,
// cross-term sum, final add), sign restore, extent multiply, rounding shift,
// then saturation into the output register.
// A two-entry output (register plus skid) lets the pipeline keep taking words
// while a result waits; ready only falls after the sink has stalled a full
// output. Corner loads give no result word; operation 3 is dropped. Columns
// and rows past the grid clamp to the last one. Configuration (index 0
// horizontal extent, 1 vertical extent, 2 flip) must only be written while idle.
module bilinear_quad_warp_grid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bqwg_in_if.sink                         in_i,
  bqwg_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [bqwg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bqwg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bqwg_pkg::*;

  // saturate to signed 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(logic signed [GW:0] v);
    if (v > $signed((GW + 1)'(32'h7fff_ffff))) begin
      return 32'sh7fff_ffff;
    end else if (v < -$signed((GW + 1)'(33'h0_8000_0000))) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  // configuration
  logic [EXT_W-1:0] ext_s_q, ext_t_q;
  logic             flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_s_q <= EXT_RESET;
      ext_t_q <= EXT_RESET;
      flip_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TEX_EXT_S: ext_s_q <= cfg_data_i[EXT_W-1:0];
        CFG_TEX_EXT_T: ext_t_q <= cfg_data_i[EXT_W-1:0];
        CFG_FLIP_VERT: flip_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves whenever the skid slot is empty
  logic skid_v_q;
  logic en;
  logic acc;

  assign en        = !skid_v_q;
  assign in_i.ready = en;
  assign acc       = in_i.valid && en;

  // ---- stage A: capture word, clamp column/row, form the four weights ----
  logic [CW-1:0] col, col_inv;
  logic [RW-1:0] row, row_inv;
  logic [3:0][WW-1:0] w_d;

  always_comb begin
    if (32'(in_i.data.grid_col) > COL_MAX) col = CW'(COL_MAX);
    else                                    col = CW'(in_i.data.grid_col);
    if (32'(in_i.data.grid_row) > ROW_MAX) row = RW'(ROW_MAX);
    else                                    row = RW'(in_i.data.grid_row);
    col_inv = CW'(COL_MAX) - col;
    row_inv = RW'(ROW_MAX) - row;
    w_d[0]  = WW'(col_inv) * WW'(row_inv);
    w_d[1]  = WW'(col)     * WW'(row_inv);
    w_d[2]  = WW'(col)     * WW'(row);
    w_d[3]  = WW'(col_inv) * WW'(row);
  end

  logic                      a_v_q;
  logic [1:0]                a_op_q;
  logic [1:0]                a_corner_q;
  logic signed [COORD_W-1:0] a_x_q, a_y_q;
  logic [3:0][WW-1:0]        a_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q     <= in_i.data.operation;
      a_corner_q <= in_i.data.corner;
      a_x_q      <= in_i.data.coord_x;
      a_y_q      <= in_i.data.coord_y;
      a_w_q      <= w_d;
    end
  end

  // corner store, written as a load word leaves stage A so that a grid point
  // in stage A sees every earlier load and none later
  logic [NCH-1:0][3:0][COORD_W-1:0] crn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crn_q <= '0;
    end else if (en && a_v_q) begin
      if (a_op_q == OP_SET_DEST) begin
        crn_q[CH_DX][a_corner_q] <= a_x_q;
        crn_q[CH_DY][a_corner_q] <= a_y_q;
      end else if (a_op_q == OP_SET_SRC) begin
        crn_q[CH_SX][a_corner_q] <= a_x_q;
        crn_q[CH_SY][a_corner_q] <= a_y_q;
      end
    end
  end

  // ---- stage B: corner times weight ----
  logic                              b_v_q;
  logic [NCH-1:0][3:0][SW-1:0]       b_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q && (a_op_q == OP_COMPUTE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        for (int k = 0; k < 4; k++) begin
          b_p_q[ch][k] <= SW'($signed(crn_q[ch][k]) * $signed({1'b0, a_w_q[k]}));
        end
      end
    end
  end

  // ---- stage C: four-term sum ----
  logic                   c_v_q;
  logic [NCH-1:0][SW-1:0] c_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        c_s_q[ch] <= b_p_q[ch][0] + b_p_q[ch][1] + b_p_q[ch][2] + b_p_q[ch][3];
      end
    end
  end

  // ---- stage N: magnitude plus half divisor ----
  logic                   n_v_q;
  logic [NCH-1:0][SW-1:0] n_num_q;
  logic [NCH-1:0]         n_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q <= 1'b0;
    end else if (en) begin
      n_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        n_neg_q[ch] <= c_s_q[ch][SW-1];
        // negative: -s + half = ~s + (half + 1)
        if (c_s_q[ch][SW-1]) n_num_q[ch] <= ~c_s_q[ch] + SW'(HALF + 1);
        else                 n_num_q[ch] <= c_s_q[ch] + SW'(HALF);
      end
    end
  end

  // ---- divider ----
  logic                        d_v;
  logic [NCH-1:0][COORD_W-1:0] d_quot;
  logic [NCH-1:0]              d_neg;

  bqwg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_v_q),
    .num_i   (n_num_q),
    .neg_i   (n_neg_q),
    .valid_o (d_v),
    .quot_o  (d_quot),
    .neg_o   (d_neg)
  );

  // ---- stage E: restore sign ----
  logic                        e_v_q;
  logic [NCH-1:0][COORD_W-1:0] e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        e_q[ch] <= d_neg[ch] ? (~d_quot[ch] + COORD_W'(1)) : d_quot[ch];
      end
    end
  end

  // ---- stage F: texture extent products (Q30.32) ----
  logic                      f_v_q;
  logic signed [COORD_W-1:0] f_vx_q, f_vy_q;
  logic signed [PW-1:0]      f_ps_q, f_pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_vx_q <= e_q[CH_DX];
      f_vy_q <= e_q[CH_DY];
      f_ps_q <= $signed(e_q[CH_SX]) * $signed({1'b0, ext_s_q});
      f_pt_q <= $signed(e_q[CH_SY]) * $signed({1'b0, ext_t_q});
    end
  end

  // ---- stage G: back to Q16.16, ties away from zero ----
  // negative p: -((-p + 0x8000) >> 16) == (p + 0x7fff) >>> 16
  logic signed [PW-1:0] rs_d, rt_d;

  always_comb begin
    rs_d = f_ps_q + (f_ps_q[PW-1] ? PW'(32767) : PW'(32768));
    rt_d = f_pt_q + (f_pt_q[PW-1] ? PW'(32767) : PW'(32768));
  end

  logic                      g_v_q;
  logic signed [COORD_W-1:0] g_vx_q, g_vy_q;
  logic signed [GW-1:0]      g_s_q, g_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_vx_q <= f_vx_q;
      g_vy_q <= f_vy_q;
      g_s_q  <= rs_d[PW-1:16];
      g_t_q  <= rt_d[PW-1:16];
    end
  end

  // ---- flip and saturate into the output word ----
  logic signed [GW:0] t_flip;
  out_word_t          res_d;

  always_comb begin
    if (flip_q) t_flip = $signed((GW + 1)'({1'b0, ext_t_q})) - (GW + 1)'(g_t_q);
    else        t_flip = (GW + 1)'(g_t_q);
    res_d.vertex_x = g_vx_q;
    res_d.vertex_y = g_vy_q;
    res_d.tex_s    = sat32((GW + 1)'(g_s_q));
    res_d.tex_t    = sat32(t_flip);
  end

  // ---- output register with skid slot ----
  logic      out_v_q;
  out_word_t out_q, skid_q;
  logic      out_free;
  logic      push;

  assign out_free = !out_v_q || out_o.ready;
  assign push     = en && g_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) out_q <= skid_q;
      else if (push) out_q <= res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

@@ rtl/bqwg_checker.sv @@
// Port-level assertions for the quad warp grid block and their bind.
`default_nettype none

module bqwg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bqwg_pkg::out_word_t out_word_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i)))
    else $error("result word changed while stalled");

  // back-pressure only ever follows a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input not ready without a stalled output");

  // one taken output word frees the input side again
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_i && out_ready_i) |=> in_ready_i)
    else $error("input stayed blocked after output drained");

  // while blocked, the output holds a word
  a_blocked_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_i && in_valid_i) |-> out_valid_i)
    else $error("input blocked with no output word pending");

endmodule

bind bilinear_quad_warp_grid bqwg_checker u_bqwg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.data)
);

`default_nettype wire
